// ===== rtl/ilfs_pkg.sv =====
// ----------------------------------------------------------------------------
// ilfs_pkg: shared types and constants of the line field splitter
// Beat kinds, mode codes, command keyword tables and the structs that pass
// between the front end, the operation queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package ilfs_pkg;

	// Default depth of the token buffer.
	localparam int TOKEN_DEPTH_DEF = 32;

	// Width of buffer counts and addresses, wide enough for the deepest buffer.
	localparam int CNT_W = 6;

	// Depth of the operation queue between front and back end.
	localparam int QUEUE_DEPTH = 4;

	typedef logic [CNT_W-1:0] cnt_t;

	// Result beat kinds.
	localparam logic [1:0] KIND_SENDER  = 2'd0;
	localparam logic [1:0] KIND_CHANNEL = 2'd1;
	localparam logic [1:0] KIND_CONTENT = 2'd2;
	localparam logic [1:0] KIND_END     = 2'd3;

	// Mode codes reported with the end beat.
	localparam logic [2:0] MODE_NONE   = 3'd0;
	localparam logic [2:0] MODE_PRIV   = 3'd1;
	localparam logic [2:0] MODE_NOTE   = 3'd2;
	localparam logic [2:0] MODE_STATUS = 3'd3;
	localparam logic [2:0] MODE_TAG    = 3'd4;
	localparam logic [2:0] MODE_OTHER  = 3'd5;

	// Characters with a special meaning.
	localparam logic [7:0] CHR_COLON = 8'h3A;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_LF    = 8'h0A;

	// Keyword text, first character in the top byte, zero padded to nine bytes.
	localparam logic [71:0] KW_PRIVMSG   = {"PRIVMSG", 16'h0000};
	localparam logic [71:0] KW_NOTICE    = {"NOTICE", 24'h000000};
	localparam logic [71:0] KW_STATUSMSG = "STATUSMSG";
	localparam logic [71:0] KW_TAGMSG    = {"TAGMSG", 24'h000000};

	// Length of keyword k.
	function automatic logic [3:0] kw_len(input logic [1:0] k);
		logic [3:0] len;
		case (k)
			2'd0: len = 4'd7;
			2'd1: len = 4'd6;
			2'd2: len = 4'd9;
			default: len = 4'd6;
		endcase
		return len;
	endfunction

	// Character at position pos of keyword k, zero past the text.
	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] pos);
		logic [71:0] text;
		logic [7:0]  chr;
		case (k)
			2'd0: text = KW_PRIVMSG;
			2'd1: text = KW_NOTICE;
			2'd2: text = KW_STATUSMSG;
			default: text = KW_TAGMSG;
		endcase
		if (pos < 4'd9) begin
			chr = text[71 - 8 * int'(pos) -: 8];
		end else begin
			chr = 8'h00;
		end
		return chr;
	endfunction

	// Mode code given by a match on keyword k.
	function automatic logic [2:0] kw_mode(input logic [1:0] k);
		logic [2:0] mode;
		case (k)
			2'd0: mode = MODE_PRIV;
			2'd1: mode = MODE_NOTE;
			2'd2: mode = MODE_STATUS;
			default: mode = MODE_TAG;
		endcase
		return mode;
	endfunction

	// Work for the back end caused by one accepted input beat.
	typedef struct packed {
		logic       push;        // store data into the token buffer at wr_addr
		cnt_t       wr_addr;
		logic [7:0] data;        // byte to store or to emit
		logic       emit;        // emit data as a content beat
		logic       flush;       // drain flush_len held bytes as flush_kind
		logic [1:0] flush_kind;
		cnt_t       flush_len;
		logic       fin;         // close the line with an end beat
		logic [2:0] mode;
		logic       ovf;
	} op_t;

	// One result beat.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [2:0] mode;
		logic       ovf;
		logic       last;
	} out_beat_t;

endpackage

`default_nettype wire

// ===== rtl/ilfs_front.sv =====
// ----------------------------------------------------------------------------
// ilfs_front: byte classifier of the line field splitter
// Tracks the field phase, matches the command against the keywords and turns
// each accepted byte into one operation for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ilfs_front #(
	parameter int TOKEN_DEPTH = ilfs_pkg::TOKEN_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_byte,
	input  wire logic          in_last,
	output logic               op_valid,
	input  wire logic          op_ready,
	output ilfs_pkg::op_t      op
);

	localparam int CW = $clog2(TOKEN_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_START,
		PH_SENDER,
		PH_COMMAND,
		PH_CHANNEL,
		PH_CSTART,
		PH_CONTENT
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [3:0]      cand_q, cand_d;
	logic [3:0]      clen_q, clen_d;
	logic [2:0]      mode_q, mode_d;
	logic            ovf_q, ovf_d;
	logic            cut_q, cut_d;
	logic            do_cmd, do_push, do_content;
	logic            accept;

	// Every byte becomes one queue entry, so the input waits only on the queue.
	assign in_ready = op_ready;
	assign op_valid = in_valid;
	assign accept   = in_valid && op_ready;

	// Classification of the current byte and next line state.
	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		cand_d     = cand_q;
		clen_d     = clen_q;
		mode_d     = mode_q;
		ovf_d      = ovf_q;
		cut_d      = cut_q;
		do_cmd     = 1'b0;
		do_push    = 1'b0;
		do_content = 1'b0;
		op         = '0;
		op.data    = in_byte;

		case (phase_q)
			PH_START: begin
				if (in_byte == ilfs_pkg::CHR_COLON) begin
					phase_d = PH_SENDER;
				end else begin
					phase_d = PH_COMMAND;
					do_cmd  = 1'b1;
				end
			end
			PH_SENDER: begin
				if (in_byte == ilfs_pkg::CHR_SPACE) begin
					op.flush      = (cnt_q != '0);
					op.flush_kind = ilfs_pkg::KIND_SENDER;
					op.flush_len  = ilfs_pkg::cnt_t'(cnt_q);
					cnt_d         = '0;
					phase_d       = PH_COMMAND;
				end else begin
					do_push = 1'b1;
				end
			end
			PH_COMMAND: begin
				do_cmd = 1'b1;
			end
			PH_CHANNEL: begin
				if (in_byte == ilfs_pkg::CHR_SPACE) begin
					op.flush      = (cnt_q != '0);
					op.flush_kind = ilfs_pkg::KIND_CHANNEL;
					op.flush_len  = ilfs_pkg::cnt_t'(cnt_q);
					cnt_d         = '0;
					phase_d       = PH_CSTART;
				end else begin
					do_push = 1'b1;
				end
			end
			PH_CSTART: begin
				phase_d    = PH_CONTENT;
				do_content = (in_byte != ilfs_pkg::CHR_COLON);
			end
			default: begin
				phase_d    = PH_CONTENT;
				do_content = 1'b1;
			end
		endcase

		// Command bytes narrow the keyword candidates; a space settles the mode.
		if (do_cmd) begin
			if (in_byte == ilfs_pkg::CHR_SPACE) begin
				mode_d = ilfs_pkg::MODE_OTHER;
				for (int k = 0; k < 4; k++) begin
					if (cand_q[k] && (ilfs_pkg::kw_len(2'(k)) == clen_q)) begin
						mode_d = ilfs_pkg::kw_mode(2'(k));
					end
				end
				cnt_d   = '0;
				phase_d = PH_CHANNEL;
			end else begin
				for (int k = 0; k < 4; k++) begin
					if ((clen_q >= ilfs_pkg::kw_len(2'(k))) ||
					    (ilfs_pkg::kw_char(2'(k), clen_q) != in_byte)) begin
						cand_d[k] = 1'b0;
					end
				end
				if (clen_q != 4'hF) begin
					clen_d = clen_q + 4'd1;
				end
				do_push = 1'b1;
			end
		end

		// Held token bytes go to the buffer until it is full.
		if (do_push) begin
			if (cnt_q < CW'(TOKEN_DEPTH)) begin
				op.push    = 1'b1;
				op.wr_addr = ilfs_pkg::cnt_t'(cnt_q);
				cnt_d      = cnt_q + CW'(1);
			end else begin
				ovf_d = 1'b1;
			end
		end

		// Content stops for the rest of the line at the first CR or LF.
		if (do_content && !cut_q) begin
			if ((in_byte == ilfs_pkg::CHR_CR) || (in_byte == ilfs_pkg::CHR_LF)) begin
				cut_d = 1'b1;
			end else begin
				op.emit = 1'b1;
			end
		end

		// At line end a pending token becomes content, then the line closes.
		if (in_last) begin
			if (((phase_d == PH_SENDER) || (phase_d == PH_COMMAND) ||
			     (phase_d == PH_CHANNEL)) && (cnt_d != '0)) begin
				op.flush      = 1'b1;
				op.flush_kind = ilfs_pkg::KIND_CONTENT;
				op.flush_len  = ilfs_pkg::cnt_t'(cnt_d);
			end
			op.fin  = 1'b1;
			op.mode = mode_d;
			op.ovf  = ovf_d;
			phase_d = PH_START;
			cnt_d   = '0;
			cand_d  = 4'hF;
			clen_d  = 4'd0;
			mode_d  = ilfs_pkg::MODE_NONE;
			ovf_d   = 1'b0;
			cut_d   = 1'b0;
		end
	end

	// Line state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			cnt_q   <= '0;
			cand_q  <= 4'hF;
			clen_q  <= 4'd0;
			mode_q  <= ilfs_pkg::MODE_NONE;
			ovf_q   <= 1'b0;
			cut_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			cand_q  <= cand_d;
			clen_q  <= clen_d;
			mode_q  <= mode_d;
			ovf_q   <= ovf_d;
			cut_q   <= cut_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ilfs_queue.sv =====
// ----------------------------------------------------------------------------
// ilfs_queue: operation queue of the line field splitter
// A short first-in first-out queue that lets the front end keep taking
// bytes while the back end drains a held token.
// ----------------------------------------------------------------------------
`default_nettype none

module ilfs_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_valid,
	output logic                wr_ready,
	input  wire ilfs_pkg::op_t  wr_data,
	output logic                rd_valid,
	input  wire logic           rd_ready,
	output ilfs_pkg::op_t       rd_data
);

	localparam int PTR_W = $clog2(ilfs_pkg::QUEUE_DEPTH);
	localparam int QCW   = $clog2(ilfs_pkg::QUEUE_DEPTH + 1);

	ilfs_pkg::op_t   slot_q [ilfs_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [QCW-1:0]   count_q;
	logic             do_wr, do_rd;

	assign wr_ready = (count_q != QCW'(ilfs_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count; pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(ilfs_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(ilfs_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ilfs_back.sv =====
// ----------------------------------------------------------------------------
// ilfs_back: beat generator of the line field splitter
// Owns the token buffer, carries out queued operations and drives the
// registered result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ilfs_back #(
	parameter int TOKEN_DEPTH = ilfs_pkg::TOKEN_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           op_valid,
	output logic                op_ready,
	input  wire ilfs_pkg::op_t  op,
	output logic                out_valid,
	input  wire logic           out_ready,
	output ilfs_pkg::out_beat_t out
);

	localparam int AW = $clog2(TOKEN_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FL_RD,
		ST_FL_OUT,
		ST_END
	} state_t;

	logic [7:0]          mem_q [TOKEN_DEPTH];
	logic [7:0]          rd_q;
	state_t              state_q;
	ilfs_pkg::cnt_t      idx_q;
	ilfs_pkg::cnt_t      len_q;
	logic [1:0]          kind_q;
	logic                fin_q;
	logic [2:0]          mode_q;
	logic                ovf_q;
	ilfs_pkg::out_beat_t out_q;
	logic                out_valid_q;
	logic                out_free;
	logic                pop;
	logic                fl_last;
	logic                fl_content;
	logic                fl_skip;
	logic                fl_cut;
	logic                beat_load;
	state_t              fl_done;

	assign out       = out_q;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	assign op_ready  = (state_q == ST_IDLE) && out_free;
	assign pop       = op_valid && op_ready;

	// Token buffer: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (pop && op.push) begin
			mem_q[op.wr_addr[AW-1:0]] <= op.data;
		end
		rd_q <= mem_q[idx_q[AW-1:0]];
	end

	// Decisions on the buffered byte under the drain index.
	assign fl_last    = ((idx_q + ilfs_pkg::cnt_t'(1)) == len_q);
	assign fl_content = (kind_q == ilfs_pkg::KIND_CONTENT);
	assign fl_skip    = fl_content && (idx_q == '0) && (rd_q == ilfs_pkg::CHR_COLON);
	assign fl_cut     = fl_content && ((rd_q == ilfs_pkg::CHR_CR) ||
	                                   (rd_q == ilfs_pkg::CHR_LF));
	assign fl_done    = fin_q ? ST_END : ST_IDLE;

	// A new result beat is loaded into the output register this cycle.
	assign beat_load  = (pop && (op.emit || (!op.flush && op.fin))) ||
	                    ((state_q == ST_FL_OUT) && !fl_cut && !fl_skip && out_free) ||
	                    ((state_q == ST_END) && out_free);

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			len_q       <= '0;
			kind_q      <= ilfs_pkg::KIND_SENDER;
			fin_q       <= 1'b0;
			mode_q      <= ilfs_pkg::MODE_NONE;
			ovf_q       <= 1'b0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (beat_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						fin_q  <= op.fin;
						mode_q <= op.mode;
						ovf_q  <= op.ovf;
						kind_q <= op.flush_kind;
						len_q  <= op.flush_len;
						idx_q  <= '0;
						if (op.emit) begin
							out_q.kind  <= ilfs_pkg::KIND_CONTENT;
							out_q.data  <= op.data;
							out_q.mode  <= ilfs_pkg::MODE_NONE;
							out_q.ovf   <= 1'b0;
							out_q.last  <= !op.fin;
							state_q     <= op.fin ? ST_END : ST_IDLE;
						end else if (op.flush) begin
							state_q <= ST_FL_RD;
						end else if (op.fin) begin
							out_q.kind  <= ilfs_pkg::KIND_END;
							out_q.data  <= 8'h00;
							out_q.mode  <= op.mode;
							out_q.ovf   <= op.ovf;
							out_q.last  <= 1'b1;
						end
					end
				end
				ST_FL_RD: begin
					state_q <= ST_FL_OUT;
				end
				ST_FL_OUT: begin
					if (fl_cut) begin
						// CR or LF in held content ends the content of the line.
						state_q <= ST_END;
					end else if (fl_skip) begin
						if (fl_last) begin
							state_q <= fl_done;
						end else begin
							idx_q   <= idx_q + ilfs_pkg::cnt_t'(1);
							state_q <= ST_FL_RD;
						end
					end else if (out_free) begin
						out_q.kind  <= kind_q;
						out_q.data  <= rd_q;
						out_q.mode  <= ilfs_pkg::MODE_NONE;
						out_q.ovf   <= 1'b0;
						out_q.last  <= !fin_q && fl_last;
						if (fl_last) begin
							state_q <= fl_done;
						end else begin
							idx_q   <= idx_q + ilfs_pkg::cnt_t'(1);
							state_q <= ST_FL_RD;
						end
					end
				end
				ST_END: begin
					if (out_free) begin
						out_q.kind  <= ilfs_pkg::KIND_END;
						out_q.data  <= 8'h00;
						out_q.mode  <= mode_q;
						out_q.ovf   <= ovf_q;
						out_q.last  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/irc_line_field_splitter_core.sv =====
// A content byte passes through an operation queue entry and then the result register.
// Throughput: one input beat per cycle while the four-entry operation queue has room.
// A held token drains byte by byte: a registered read of the token buffer in ST_FL_RD,
// then the beat in ST_FL_OUT; the end beat follows from ST_END.
// Reset: arst_n clears all line state and empties the queue; the token buffer
// contents stay undefined and are only read after being written.
// ----------------------------------------------------------------------------
// irc_line_field_splitter_core: chat protocol line field splitter
// Splits a line, one byte per beat, into sender, channel and content beats
// followed by an end beat with the command mode and an overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module irc_line_field_splitter_core #(
	parameter int TOKEN_DEPTH = ilfs_pkg::TOKEN_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] line_byte
	input  wire logic        s_axis_tlast,   // line_end
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [7:0] field_byte, [10:8] mode_code,
	                                         // [11] overflowed, [15:12] zero
	output logic [1:0]       m_axis_tuser,   // [1:0] field_kind
	output logic             m_axis_tlast    // run_last
);

	ilfs_pkg::op_t       fe_op;
	logic                fe_valid;
	logic                fe_ready;
	ilfs_pkg::op_t       be_op;
	logic                be_valid;
	logic                be_ready;
	ilfs_pkg::out_beat_t beat;

	// Front end: classify each byte into one operation.
	ilfs_front #(
		.TOKEN_DEPTH(TOKEN_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.op_valid (fe_valid),
		.op_ready (fe_ready),
		.op       (fe_op)
	);

	// Queue between classification and beat generation.
	ilfs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fe_valid),
		.wr_ready (fe_ready),
		.wr_data  (fe_op),
		.rd_valid (be_valid),
		.rd_ready (be_ready),
		.rd_data  (be_op)
	);

	// Back end: token buffer and result beats.
	ilfs_back #(
		.TOKEN_DEPTH(TOKEN_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (be_valid),
		.op_ready  (be_ready),
		.op        (be_op),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out       (beat)
	);

	// Pack the result beat onto the output bus.
	assign m_axis_tdata = {4'b0000, beat.ovf, beat.mode, beat.data};
	assign m_axis_tuser = beat.kind;
	assign m_axis_tlast = beat.last;

endmodule

`default_nettype wire

// ===== sim/tb_irc_line_field_splitter_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_irc_line_field_splitter_core: self-checking bench of the line splitter
// Feeds chat protocol lines one byte per beat, first a few hand-made lines for
// the corner cases and then random lines, most of them well formed. A
// scoreboard predicts every sender, channel, content and end beat and checks
// the output stream beat by beat under random source gaps and sink stalls.
// ----------------------------------------------------------------------------

module tb_irc_line_field_splitter_core;

	localparam int DEPTH        = ilfs_pkg::TOKEN_DEPTH_DEF;
	localparam int LINE_BYTES   = 310;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_HOLD    = 80;

	// Where the splitter stands within the current line.
	typedef enum logic [2:0] {
		LP_START, LP_SENDER, LP_COMMAND, LP_CHANNEL, LP_CONTENT_START, LP_CONTENT
	} line_phase_t;

	// Predicts the beats of each line and checks the output stream against them.
	class splitter_scoreboard;
		ilfs_pkg::out_beat_t beats_due[$];
		int          errors;
		line_phase_t phase;
		logic [7:0]  held[$];
		logic [3:0]  cands;
		logic [3:0]  cmd_len;
		logic [2:0]  mode;
		logic        ovf;
		logic        cut;
		string       kw_text[4] = '{"PRIVMSG", "NOTICE", "STATUSMSG", "TAGMSG"};
		logic [2:0]  kw_code[4] = '{ilfs_pkg::MODE_PRIV, ilfs_pkg::MODE_NOTE,
		                            ilfs_pkg::MODE_STATUS, ilfs_pkg::MODE_TAG};

		function new();
			errors = 0;
			clear_line();
		endfunction

		function void clear_line();
			phase = LP_START;
			held.delete();
			cands = 4'hF;
			cmd_len = 4'd0;
			mode = ilfs_pkg::MODE_NONE;
			ovf = 1'b0;
			cut = 1'b0;
		endfunction

		function void emit(logic [1:0] kind, logic [7:0] data);
			ilfs_pkg::out_beat_t b;
			b = '{kind: kind, data: data, mode: ilfs_pkg::MODE_NONE, ovf: 1'b0, last: 1'b0};
			beats_due.push_back(b);
		endfunction

		// Bytes past the buffer depth are lost and flagged.
		function void hold_byte(logic [7:0] b);
			if (held.size() < DEPTH) begin
				held.push_back(b);
			end else begin
				ovf = 1'b1;
			end
		endfunction

		// Content stops for good at the first CR or LF.
		function void content_out(logic [7:0] b);
			if (cut) begin
				return;
			end
			if (b == ilfs_pkg::CHR_CR || b == ilfs_pkg::CHR_LF) begin
				cut = 1'b1;
			end else begin
				emit(ilfs_pkg::KIND_CONTENT, b);
			end
		endfunction

		function void flush_held(logic [1:0] kind);
			foreach (held[i]) begin
				emit(kind, held[i]);
			end
			held.delete();
		endfunction

		// Matching narrows the keyword set on every byte, even dropped ones.
		function void command_in(logic [7:0] b);
			if (b == ilfs_pkg::CHR_SPACE) begin
				mode = ilfs_pkg::MODE_OTHER;
				for (int k = 0; k < 4; k++) begin
					if (cands[k] && kw_text[k].len() == cmd_len) begin
						mode = kw_code[k];
					end
				end
				held.delete();
				phase = LP_CHANNEL;
				return;
			end
			for (int k = 0; k < 4; k++) begin
				if (cmd_len >= kw_text[k].len() || kw_text[k][cmd_len] != b) begin
					cands[k] = 1'b0;
				end
			end
			if (cmd_len < 4'd15) begin
				cmd_len++;
			end
			hold_byte(b);
		endfunction

		// Works out the beats caused by one accepted line byte.
		function void note_line_byte(logic [7:0] b, logic line_end);
			int        base;
			int        first;
			ilfs_pkg::out_beat_t e;
			base = beats_due.size();
			case (phase)
				LP_START: begin
					if (b == ilfs_pkg::CHR_COLON) begin
						phase = LP_SENDER;
					end else begin
						phase = LP_COMMAND;
						command_in(b);
					end
				end
				LP_SENDER: begin
					if (b == ilfs_pkg::CHR_SPACE) begin
						flush_held(ilfs_pkg::KIND_SENDER);
						phase = LP_COMMAND;
					end else begin
						hold_byte(b);
					end
				end
				LP_COMMAND: begin
					command_in(b);
				end
				LP_CHANNEL: begin
					if (b == ilfs_pkg::CHR_SPACE) begin
						flush_held(ilfs_pkg::KIND_CHANNEL);
						phase = LP_CONTENT_START;
					end else begin
						hold_byte(b);
					end
				end
				LP_CONTENT_START: begin
					phase = LP_CONTENT;
					if (b != ilfs_pkg::CHR_COLON) begin
						content_out(b);
					end
				end
				default: begin
					content_out(b);
				end
			endcase
			if (line_end) begin
				// A token still waiting for its space turns into content.
				if (phase == LP_SENDER || phase == LP_COMMAND || phase == LP_CHANNEL) begin
					first = (held.size() > 0 && held[0] == ilfs_pkg::CHR_COLON) ? 1 : 0;
					for (int i = first; i < held.size(); i++) begin
						content_out(held[i]);
					end
					held.delete();
				end
				e = '{kind: ilfs_pkg::KIND_END, data: 8'h00, mode: mode, ovf: ovf, last: 1'b0};
				beats_due.push_back(e);
				clear_line();
			end
			if (beats_due.size() > base) begin
				e = beats_due.pop_back();
				e.last = 1'b1;
				beats_due.push_back(e);
			end
		endfunction

		function void compare(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [1:0] kind, logic [15:0] data, logic last);
			ilfs_pkg::out_beat_t e;
			if (beats_due.size() == 0) begin
				$error("output beat with nothing expected: kind %0d data 0x%0h", kind, data);
				errors++;
				return;
			end
			e = beats_due.pop_front();
			compare("field_kind", e.kind, kind);
			compare("field_byte", e.data, data[7:0]);
			compare("mode_code", e.mode, data[10:8]);
			compare("overflowed", e.ovf, data[11]);
			compare("tdata pad", 0, data[15:12]);
			compare("run_last", e.last, last);
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] line_byte
	logic        s_axis_tlast = 1'b0;    // line_end
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;           // [7:0] field_byte, [10:8] mode_code, [11] overflowed
	logic [1:0]  m_axis_tuser;           // [1:0] field_kind
	logic        m_axis_tlast;           // run_last

	splitter_scoreboard sb = new();

	logic [7:0] line_q[$];
	int         burst_left = 0;
	int         bytes_sent = 0;
	int         idle_cycles = 0;
	logic       hold_due = 1'b0;

	irc_line_field_splitter_core #(
		.TOKEN_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Mostly printable bytes, with a share of any value and of the special ones.
	function automatic logic [7:0] pick_byte();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			return 8'($urandom_range(33, 126));
		end else if (r < 8) begin
			return 8'($urandom_range(0, 255));
		end
		case ($urandom_range(0, 4))
			0: return ilfs_pkg::CHR_COLON;
			1: return ilfs_pkg::CHR_CR;
			2: return ilfs_pkg::CHR_LF;
			3: return 8'h00;
			default: return 8'hFF;
		endcase
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			line_q.push_back(s[i]);
		end
	endfunction

	// A token never holds a space; now and then it is long enough to overflow.
	function automatic void add_token(int len);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = pick_byte();
			if (b == ilfs_pkg::CHR_SPACE) begin
				b = 8'h5F;
			end
			line_q.push_back(b);
		end
	endfunction

	function automatic int token_len(logic big);
		if (big || $urandom_range(0, 14) == 0) begin
			return $urandom_range(DEPTH - 2, DEPTH + 8);
		end
		return $urandom_range(0, 8);
	endfunction

	// Builds a random line in line_q: mostly well formed, some noise or cut short.
	function automatic void build_line(logic big);
		string kw;
		int    n;
		line_q.delete();
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				line_q.push_back(($urandom_range(0, 4) == 0) ? ilfs_pkg::CHR_SPACE :
				                 pick_byte());
			end
			return;
		end
		if (big || $urandom_range(0, 2) != 0) begin
			line_q.push_back(ilfs_pkg::CHR_COLON);
			add_token(token_len(big));
			line_q.push_back(ilfs_pkg::CHR_SPACE);
		end
		case ($urandom_range(0, 4))
			0: kw = "PRIVMSG";
			1: kw = "NOTICE";
			2: kw = "STATUSMSG";
			default: kw = "TAGMSG";
		endcase
		case (big ? 7 : $urandom_range(0, 9))
			0, 1, 2, 3: add_text(kw);
			4: ;
			5: add_token(token_len(1'b0) + 1);
			6: add_text(kw.substr(0, kw.len() - 2));
			7: begin
				add_text(kw);
				add_token($urandom_range(1, 12));
			end
			default: begin
				add_text(kw);
				line_q.push_back(8'($urandom_range(65, 90)));
			end
		endcase
		line_q.push_back(ilfs_pkg::CHR_SPACE);
		if ($urandom_range(0, 1) == 0) begin
			line_q.push_back(8'h23);
		end
		add_token(token_len(1'b0));
		line_q.push_back(ilfs_pkg::CHR_SPACE);
		if ($urandom_range(0, 1) == 0) begin
			line_q.push_back(ilfs_pkg::CHR_COLON);
		end
		n = $urandom_range(0, 14);
		for (int i = 0; i < n; i++) begin
			line_q.push_back(($urandom_range(0, 5) == 0) ? ilfs_pkg::CHR_SPACE :
			                 pick_byte());
		end
		if ($urandom_range(0, 2) != 0) begin
			line_q.push_back(ilfs_pkg::CHR_CR);
			line_q.push_back(ilfs_pkg::CHR_LF);
		end
		// A broken line ends somewhere inside its fields.
		if ($urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, line_q.size());
			line_q = line_q[0:n-1];
		end
	endfunction

	// Offers one byte in bursts of random length with random gaps in between.
	task automatic send_beat(input logic [7:0] b, input logic line_end);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= line_end;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_line_byte(b, line_end);
		bytes_sent++;
	endtask

	task automatic send_line();
		foreach (line_q[i]) begin
			send_beat(line_q[i], i == line_q.size() - 1);
		end
	endtask

	// Sink: checks each beat taken, then stalls on runs of random style.
	always @(posedge clk) begin
		static int hold_left = 0;
		static int style = 0;
		static int style_left = 0;
		if (m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
		end
		if (hold_due) begin
			hold_due = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			if (style_left == 0) begin
				style = $urandom_range(0, 2);
				style_left = $urandom_range(5, 60);
			end
			style_left--;
			case (style)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				default: m_axis_tready <= ($urandom_range(0, 2) == 0);
			endcase
		end
	end

	// Watchdog on cycles in which no beat moves on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int line_no;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lone leading colon.
		line_q.delete();
		add_text(":");
		send_line();
		// Command cut short by the line end becomes content.
		line_q.delete();
		add_text("A");
		send_line();
		// Empty command.
		line_q.delete();
		add_text(" ");
		send_line();
		// Empty sender and channel, colon opening content, CR at the end.
		line_q.delete();
		add_text(": N  :");
		line_q.push_back(ilfs_pkg::CHR_CR);
		send_line();
		// All-ones and zero bytes as plain content.
		line_q.delete();
		line_q.push_back(8'hFF);
		line_q.push_back(8'h00);
		send_line();
		// Held command with a leading colon, cut by LF at line end.
		line_q.delete();
		add_text(": :q");
		line_q.push_back(ilfs_pkg::CHR_LF);
		add_text("z");
		send_line();
		// CR inside a sender token passes through.
		line_q.delete();
		line_q.push_back(ilfs_pkg::CHR_COLON);
		line_q.push_back(ilfs_pkg::CHR_CR);
		add_text(" X");
		send_line();

		// Random lines; the sink holds off once early so the input backs up.
		hold_due = 1'b1;
		line_no = 0;
		while (bytes_sent < LINE_BYTES) begin
			build_line(line_no == 0);
			send_line();
			line_no++;
		end
		s_axis_tvalid <= 1'b0;

		while (sb.beats_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ilfs_pkg.sv
rtl/ilfs_front.sv
rtl/ilfs_queue.sv
rtl/ilfs_back.sv
rtl/irc_line_field_splitter_core.sv
sim/tb_irc_line_field_splitter_core.sv
